[hdl/ahs_pkg.sv]
package ahs_pkg;

  typedef logic signed [31:0] trig_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } trig_pair_t;

  typedef struct packed {
    logic [14:0] cell_slope;
    logic [15:0] cell_aspect;
    logic        cell_valid;
  } in_item_t;

  typedef struct packed {
    logic [15:0] shade_angle;
    logic        shade_valid;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] wdata;
  } cfg_req_t;

  localparam logic [7:0] REG_AZIMUTH = 8'd0;
  localparam logic [7:0] REG_HEIGHT  = 8'd1;
  localparam logic [7:0] REG_GAIN    = 8'd2;
  localparam logic [7:0] REG_MODE    = 8'd3;

  localparam logic [1:0] MODE_STD   = 2'd0;
  localparam logic [1:0] MODE_CAP   = 2'd1;
  localparam logic [1:0] MODE_SLOPE = 2'd2;

  localparam logic [15:0] AZIMUTH_RST = 16'd57344;
  localparam logic [14:0] HEIGHT_RST  = 15'd8192;
  localparam logic [15:0] GAIN_ONE    = 16'd256;
  localparam logic [14:0] RIGHT_ANGLE = 15'd16384;

  localparam logic [31:0] CORDIC_K = 32'd652032874;

  localparam logic [31:0] ATAN_TAB [25] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028
  };

  // atan(2^-step) rounded to 2^abits units per turn
  function automatic logic [31:0] atan_step(int step, int abits);
    logic [32:0] t;
    t = {1'b0, ATAN_TAB[step]} + (33'd1 << (31 - abits));
    return 32'(t >> (32 - abits));
  endfunction

  // 16-bit angle to internal angle units
  function automatic logic [31:0] to_int(logic [31:0] v, int abits);
    if (abits >= 16) begin
      return v << (abits - 16);
    end
    return (v + (32'd1 << (15 - abits))) >> (16 - abits);
  endfunction

  // internal angle units to 16-bit angle
  function automatic logic [31:0] from_int(logic [31:0] u, int abits);
    if (abits > 16) begin
      return (u + (32'd1 << (abits - 17))) >> (abits - 16);
    end
    if (abits < 16) begin
      return u << (16 - abits);
    end
    return u;
  endfunction

endpackage

[hdl/ahs_stream_if.sv]
interface ahs_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/ahs_delay.sv]
module ahs_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign q_o = line_r[DEPTH-1];

endmodule

[hdl/ahs_cordic_cell.sv]
module ahs_cordic_cell #(
  parameter int W      = 33,
  parameter int ZW     = 18,
  parameter int STEP   = 0,
  parameter int ABITS  = 16,
  parameter bit VECTOR = 1'b0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic [31:0] TAB = ahs_pkg::atan_step(STEP, ABITS);
  localparam logic signed [ZW-1:0] ANG = signed'(TAB[ZW-1:0]);

  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 pos;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (VECTOR) begin
      pos = y_i[W-1] || (y_i == '0);
    end else begin
      pos = !z_i[ZW-1];
    end
    if (pos) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ANG;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

[hdl/ahs_sqrt_cell.sv]
module ahs_sqrt_cell #(
  parameter int SW  = 61,
  parameter int BIT = 60
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] v_i,
  input  logic [SW-1:0] r_i,
  output logic [SW-1:0] v_o,
  output logic [SW-1:0] r_o
);

  localparam logic [SW-1:0] ONE_BIT = {{(SW-1){1'b0}}, 1'b1} << BIT;

  logic [SW:0]   sum;
  logic [SW-1:0] v_r, r_r, v_nxt, r_nxt;

  always_comb begin
    sum = {1'b0, r_i} + {1'b0, ONE_BIT};
    if ({1'b0, v_i} >= sum) begin
      v_nxt = v_i - sum[SW-1:0];
      r_nxt = (r_i >> 1) + ONE_BIT;
    end else begin
      v_nxt = v_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
    end
  end

  assign v_o = v_r;
  assign r_o = r_r;

endmodule

[hdl/analytical_hillshade.sv]
// channel  dir  handshake      payload
// in_if    in   valid/ready    cell_slope, cell_aspect, cell_valid
// out_if   out  valid/ready    shade_angle, shade_valid
// cfg_if   in   valid/ready    index, wdata (ready always high)
// One request per cycle while results are taken; the pipeline is built from the
// CORDIC cell rows and the 31-cell square-root row.
// Reset clears stage valids and loads the configuration defaults.
// A result not taken holds the whole pipeline; in_if.ready follows it.
module analytical_hillshade #(
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  ahs_stream_if.sink   in_if,
  ahs_stream_if.source out_if,
  ahs_stream_if.sink   cfg_if
);

  localparam int A   = ANGLE_BITS;
  localparam int N   = TRIG_STEPS;
  localparam int ZW  = A + 2;
  localparam int SLW = A - 1;
  localparam int RW  = 33;
  localparam int GW  = 42;
  localparam int FW  = 34;
  localparam int SW  = 61;
  localparam int PW  = 2 * A;
  localparam int LAT = 4 * N + 44;

  localparam logic signed [ZW-1:0] QUARTER_Z = ZW'(1) << (A - 2);
  localparam logic signed [ZW-1:0] HALF_Z    = ZW'(1) << (A - 1);
  localparam logic [A-1:0]         QUARTER_A = A'(1) << (A - 2);
  localparam logic [PW-1:0]        QHALF_P   = PW'(1) << (A - 3);
  localparam logic signed [RW-1:0] QONE_R    = RW'(1) << 30;
  localparam logic signed [RW-1:0] K_R       = signed'({1'b0, ahs_pkg::CORDIC_K});

  function automatic ahs_pkg::trig_t clampq(logic signed [RW-1:0] v);
    if (v > QONE_R) begin
      return 32'sd1073741824;
    end
    if (v < -QONE_R) begin
      return -32'sd1073741824;
    end
    return v[31:0];
  endfunction

  function automatic ahs_pkg::trig_pair_t rot_out(ahs_pkg::trig_t x, ahs_pkg::trig_t y,
                                                  logic [1:0] q);
    ahs_pkg::trig_pair_t p;
    case (q)
      2'd0: begin p.c = x;  p.s = y;  end
      2'd1: begin p.c = -y; p.s = x;  end
      2'd2: begin p.c = -x; p.s = -y; end
      default: begin p.c = y; p.s = -x; end
    endcase
    return p;
  endfunction

  function automatic logic signed [ZW-1:0] quad_rem(logic [A-1:0] a);
    return signed'({{(ZW-A+2){1'b0}}, a[A-3:0]});
  endfunction

  function automatic ahs_pkg::trig_t qmul(ahs_pkg::trig_t a, ahs_pkg::trig_t b);
    logic [30:0] ma, mb;
    logic [61:0] m;
    logic [31:0] r;
    ma = a[31] ? 31'(-a) : a[30:0];
    mb = b[31] ? 31'(-b) : b[30:0];
    m  = 62'(ma) * 62'(mb) + (62'd1 << 29);
    r  = {1'b0, m[60:30]};
    return (a[31] ^ b[31]) ? -signed'(r) : signed'(r);
  endfunction

  function automatic logic signed [ZW-1:0] zclamp(logic signed [ZW-1:0] z);
    if (z < 0) begin
      return '0;
    end
    if (z > QUARTER_Z) begin
      return QUARTER_Z;
    end
    return z;
  endfunction

  // configuration
  logic [15:0] az_r;
  logic [14:0] hgt_r;
  logic [15:0] gain_r;
  logic [1:0]  mode_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_r   <= ahs_pkg::AZIMUTH_RST;
      hgt_r  <= ahs_pkg::HEIGHT_RST;
      gain_r <= ahs_pkg::GAIN_ONE;
      mode_r <= ahs_pkg::MODE_STD;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.index)
        ahs_pkg::REG_AZIMUTH: az_r   <= cfg_if.data.wdata;
        ahs_pkg::REG_HEIGHT:  hgt_r  <= cfg_if.data.wdata[14:0];
        ahs_pkg::REG_GAIN:    gain_r <= cfg_if.data.wdata;
        ahs_pkg::REG_MODE:    mode_r <= cfg_if.data.wdata[1:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic [LAT-1:0] vld_r;
  logic           adv, acc;

  assign adv         = !vld_r[LAT-1] || out_if.ready;
  assign acc         = in_if.valid && adv;
  assign in_if.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], acc};
    end
  end

  // input stage
  logic [14:0]    slope_sat, hgt_sat;
  logic [31:0]    s_int, h_int, asp_int, az_int, da_full;
  logic [SLW-1:0] s0_r, h0_r;
  logic [A-1:0]   da0_r;
  logic           nd0_r;

  always_comb begin
    slope_sat = (in_if.data.cell_slope > ahs_pkg::RIGHT_ANGLE) ? ahs_pkg::RIGHT_ANGLE
                                                               : in_if.data.cell_slope;
    hgt_sat   = (hgt_r > ahs_pkg::RIGHT_ANGLE) ? ahs_pkg::RIGHT_ANGLE : hgt_r;
    s_int     = ahs_pkg::to_int(32'(slope_sat), A);
    h_int     = ahs_pkg::to_int(32'(hgt_sat), A);
    asp_int   = ahs_pkg::to_int(32'(in_if.data.cell_aspect), A);
    az_int    = ahs_pkg::to_int(32'(az_r), A);
    da_full   = asp_int - az_int;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r  <= s_int[SLW-1:0];
      h0_r  <= h_int[SLW-1:0];
      da0_r <= da_full[A-1:0];
      nd0_r <= !in_if.data.cell_valid;
    end
  end

  // exaggeration: sin/cos of slope
  logic [A-1:0]         gang;
  logic signed [RW-1:0] gx_w [N+1];
  logic signed [RW-1:0] gy_w [N+1];
  logic signed [ZW-1:0] gz_w [N+1];
  logic [1:0]           gq_d;

  assign gang    = {1'b0, s0_r};
  assign gx_w[0] = K_R;
  assign gy_w[0] = '0;
  assign gz_w[0] = quad_rem(gang);

  for (genvar j = 0; j < N; j++) begin : g_grot
    ahs_cordic_cell #(.W(RW), .ZW(ZW), .STEP(j), .ABITS(A), .VECTOR(1'b0)) u_cell (
      .clk(clk), .en(adv),
      .x_i(gx_w[j]), .y_i(gy_w[j]), .z_i(gz_w[j]),
      .x_o(gx_w[j+1]), .y_o(gy_w[j+1]), .z_o(gz_w[j+1])
    );
  end

  ahs_delay #(.W(2), .DEPTH(N)) u_gq (
    .clk(clk), .en(adv), .d_i(gang[A-1:A-2]), .q_o(gq_d)
  );

  ahs_pkg::trig_pair_t gp;
  logic [30:0]         gc_r, gs_r, gcb_r;
  logic [46:0]         gprod;
  logic [38:0]         yv_r;

  assign gp    = rot_out(clampq(gx_w[N]), clampq(gy_w[N]), gq_d);
  assign gprod = 47'(gs_r) * 47'(gain_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      gc_r  <= gp.c[31] ? '0 : gp.c[30:0];
      gs_r  <= gp.s[31] ? '0 : gp.s[30:0];
      gcb_r <= gc_r;
      yv_r  <= gprod[46:8];
    end
  end

  // exaggeration: atan2
  logic signed [GW-1:0] vx_w [N+1];
  logic signed [GW-1:0] vy_w [N+1];
  logic signed [ZW-1:0] vz_w [N+1];

  assign vx_w[0] = signed'({{(GW-31){1'b0}}, gcb_r});
  assign vy_w[0] = signed'({{(GW-39){1'b0}}, yv_r});
  assign vz_w[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_gvec
    ahs_cordic_cell #(.W(GW), .ZW(ZW), .STEP(j), .ABITS(A), .VECTOR(1'b1)) u_cell (
      .clk(clk), .en(adv),
      .x_i(vx_w[j]), .y_i(vy_w[j]), .z_i(vz_w[j]),
      .x_o(vx_w[j+1]), .y_o(vy_w[j+1]), .z_o(vz_w[j+1])
    );
  end

  logic [SLW-1:0]       s_d, h_d, s1_r, s_dd;
  logic [A-1:0]         da_d;
  logic                 nd_d;
  logic signed [ZW-1:0] gzc;

  ahs_delay #(.W(SLW), .DEPTH(2*N+2)) u_sd (
    .clk(clk), .en(adv), .d_i(s0_r), .q_o(s_d)
  );
  ahs_delay #(.W(SLW), .DEPTH(2*N+3)) u_hd (
    .clk(clk), .en(adv), .d_i(h0_r), .q_o(h_d)
  );
  ahs_delay #(.W(A), .DEPTH(2*N+3)) u_dad (
    .clk(clk), .en(adv), .d_i(da0_r), .q_o(da_d)
  );
  ahs_delay #(.W(1), .DEPTH(4*N+42)) u_nd (
    .clk(clk), .en(adv), .d_i(nd0_r), .q_o(nd_d)
  );

  assign gzc = zclamp(vz_w[N]);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (gain_r == ahs_pkg::GAIN_ONE) begin
        s1_r <= s_d;
      end else if (gain_r == '0) begin
        s1_r <= '0;
      end else begin
        s1_r <= gzc[SLW-1:0];
      end
    end
  end

  // main sin/cos rows: slope, height, aspect minus azimuth
  logic [A-1:0]         mang [3];
  logic signed [RW-1:0] mx_w [3][N+1];
  logic signed [RW-1:0] my_w [3][N+1];
  logic signed [ZW-1:0] mz_w [3][N+1];
  logic [5:0]           mq_d;

  assign mang[0] = {1'b0, s1_r};
  assign mang[1] = {1'b0, h_d};
  assign mang[2] = da_d;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign mx_w[l][0] = K_R;
    assign my_w[l][0] = '0;
    assign mz_w[l][0] = quad_rem(mang[l]);
    for (genvar j = 0; j < N; j++) begin : g_rot
      ahs_cordic_cell #(.W(RW), .ZW(ZW), .STEP(j), .ABITS(A), .VECTOR(1'b0)) u_cell (
        .clk(clk), .en(adv),
        .x_i(mx_w[l][j]), .y_i(my_w[l][j]), .z_i(mz_w[l][j]),
        .x_o(mx_w[l][j+1]), .y_o(my_w[l][j+1]), .z_o(mz_w[l][j+1])
      );
    end
  end

  ahs_delay #(.W(6), .DEPTH(N)) u_mq (
    .clk(clk), .en(adv),
    .d_i({mang[2][A-1:A-2], mang[1][A-1:A-2], mang[0][A-1:A-2]}), .q_o(mq_d)
  );

  ahs_pkg::trig_pair_t ps, ph, pa;
  ahs_pkg::trig_t      cs_r, ss_r, ch_r, sh_r, ca_r, ca_b_r, p1_r, p2_r, p1c_r, p3_r;
  ahs_pkg::trig_t      c_r, c_e_r, c_f_r, c_s;
  logic signed [32:0]  csum;
  logic [30:0]         cmag, smag;
  logic [61:0]         csq;
  logic [60:0]         cc_r, rad_r;

  assign ps   = rot_out(clampq(mx_w[0][N]), clampq(my_w[0][N]), mq_d[1:0]);
  assign ph   = rot_out(clampq(mx_w[1][N]), clampq(my_w[1][N]), mq_d[3:2]);
  assign pa   = rot_out(clampq(mx_w[2][N]), clampq(my_w[2][N]), mq_d[5:4]);
  assign csum = 33'(p1c_r) + 33'(p3_r);
  assign cmag = c_r[31] ? 31'(-c_r) : c_r[30:0];
  assign csq  = 62'(cmag) * 62'(cmag);

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r   <= ps.c;
      ss_r   <= ps.s;
      ch_r   <= ph.c;
      sh_r   <= ph.s;
      ca_r   <= pa.c;
      p1_r   <= qmul(cs_r, sh_r);
      p2_r   <= qmul(ss_r, ch_r);
      ca_b_r <= ca_r;
      p1c_r  <= p1_r;
      p3_r   <= qmul(p2_r, ca_b_r);
      c_r    <= clampq(csum);
      cc_r   <= csq[60:0];
      c_e_r  <= c_r;
      rad_r  <= (61'd1 << 60) - cc_r;
      c_f_r  <= c_e_r;
    end
  end

  // isqrt(1 - c*c)
  logic [SW-1:0] sv_w [32];
  logic [SW-1:0] sr_w [32];

  assign sv_w[0] = rad_r;
  assign sr_w[0] = '0;

  for (genvar j = 0; j < 31; j++) begin : g_sqrt
    ahs_sqrt_cell #(.SW(SW), .BIT(60 - 2*j)) u_cell (
      .clk(clk), .en(adv),
      .v_i(sv_w[j]), .r_i(sr_w[j]), .v_o(sv_w[j+1]), .r_o(sr_w[j+1])
    );
  end

  ahs_delay #(.W(32), .DEPTH(31)) u_cs (
    .clk(clk), .en(adv), .d_i(c_f_r), .q_o(c_s)
  );

  // acos via atan2
  logic signed [FW-1:0] fx_w [N+1];
  logic signed [FW-1:0] fy_w [N+1];
  logic signed [ZW-1:0] fz_w [N+1];
  logic                 flip_d;

  assign smag    = c_s[31] ? 31'(-c_s) : c_s[30:0];
  assign fx_w[0] = signed'({{(FW-31){1'b0}}, smag});
  assign fy_w[0] = signed'({{(FW-31){1'b0}}, sr_w[31][30:0]});
  assign fz_w[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_fvec
    ahs_cordic_cell #(.W(FW), .ZW(ZW), .STEP(j), .ABITS(A), .VECTOR(1'b1)) u_cell (
      .clk(clk), .en(adv),
      .x_i(fx_w[j]), .y_i(fy_w[j]), .z_i(fz_w[j]),
      .x_o(fx_w[j+1]), .y_o(fy_w[j+1]), .z_o(fz_w[j+1])
    );
  end

  ahs_delay #(.W(1), .DEPTH(N)) u_flip (
    .clk(clk), .en(adv), .d_i(c_s[31]), .q_o(flip_d)
  );
  ahs_delay #(.W(SLW), .DEPTH(2*N+38)) u_sdd (
    .clk(clk), .en(adv), .d_i(s1_r), .q_o(s_dd)
  );

  // mode and output
  logic signed [ZW-1:0] fzc, dz;
  logic [A-1:0]         d_r, dm_r, val;
  logic [PW-1:0]        prod_r;
  logic [31:0]          fi;
  ahs_pkg::out_item_t   out_r, out_nxt;

  always_comb begin
    fzc = zclamp(fz_w[N]);
    dz  = flip_d ? HALF_Z - fzc : fzc;
    val = (mode_r == ahs_pkg::MODE_SLOPE) ? prod_r[A-2 +: A] : dm_r;
    fi  = ahs_pkg::from_int(32'(val), A);
    out_nxt.shade_angle = nd_d ? '0 : fi[15:0];
    out_nxt.shade_valid = !nd_d;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r    <= dz[A-1:0];
      dm_r   <= (mode_r == ahs_pkg::MODE_CAP && d_r > QUARTER_A) ? QUARTER_A : d_r;
      prod_r <= PW'(d_r) * PW'(s_dd) + QHALF_P;
      out_r  <= out_nxt;
    end
  end

  assign out_if.valid = vld_r[LAT-1];
  assign out_if.data  = out_r;

endmodule
